// ===== hdl/nrtp_pkg.sv =====
// Shared types, codes and sizes of the nested region time profiler.
package nrtp_pkg;

   localparam int TS_W         = 63;
   localparam int REGION_W     = 5;
   localparam int COUNT_W      = 6;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int MASK_W       = 32;
   localparam int MAX_REGIONS_DEF = 32;
   localparam int STACK_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH  = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [REGION_W-1:0] region;
      logic [TS_W-1:0]     now_real_us;
      logic [TS_W-1:0]     now_user_us;
      logic [TS_W-1:0]     now_sys_us;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TS_W-1:0]     event_time;
      logic [TS_W-1:0]     real_total;
      logic [TS_W-1:0]     user_total;
      logic [TS_W-1:0]     sys_total;
      logic [MASK_W-1:0]   child_mask;
   } rsp_type;

   // Classified transaction as it waits between front and back
   typedef struct packed {
      req_type req;
      logic    region_ok;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hdl/nrtp_front.sv =====
// Front end: region count register, transaction intake and region range check.
module nrtp_front #(
   parameter int MAX_REGIONS = nrtp_pkg::MAX_REGIONS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [nrtp_pkg::COUNT_W-1:0]     csr_write_data,
   input  logic                             req_valid,
   input  nrtp_pkg::req_type                req_data,
   output logic                             req_stall,
   input  nrtp_pkg::queue_status_type       queue_status,
   output logic                             push_valid,
   output nrtp_pkg::item_type               push_item
);
   import nrtp_pkg::*;

   localparam int CMP_W = COUNT_W + 2;

   logic [COUNT_W-1:0] region_count_ff;
   logic [COUNT_W-1:0] region_count_in;
   logic               region_ok;

   // Hold the region count until software rewrites it
   always_comb begin
      region_count_in = region_count_ff;
      if (csr_write_enable) begin
         region_count_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_count_ff <= '0;
      end else begin
         region_count_ff <= region_count_in;
      end
   end

   // Classify the region against the configured count and the table size
   assign region_ok = (CMP_W'(req_data.region) < CMP_W'(region_count_ff)) &&
                      (CMP_W'(req_data.region) < CMP_W'(MAX_REGIONS));

   // Pass the transaction on while the queue has room
   assign req_stall           = queue_status.full;
   assign push_valid          = req_valid && !queue_status.full;
   assign push_item.req       = req_data;
   assign push_item.region_ok = region_ok;

endmodule

// ===== hdl/nrtp_queue.sv =====
// Short queue of classified transactions between front and back end.
module nrtp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  nrtp_pkg::item_type          push_item,
   input  logic                        pop,
   output nrtp_pkg::item_type          head_item,
   output nrtp_pkg::queue_status_type  queue_status
);
   import nrtp_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff;
   logic [IDX_W-1:0]   wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff;
   logic [IDX_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign queue_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign do_push = push_valid && !queue_status.full;
   assign do_pop  = pop && !queue_status.empty;
   assign head_item = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap and track the fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/nrtp_back.sv =====
// Back end: region stack, accumulator table read-modify-write and result register.
module nrtp_back #(
   parameter int MAX_REGIONS = nrtp_pkg::MAX_REGIONS_DEF,
   parameter int STACK_DEPTH = nrtp_pkg::STACK_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  nrtp_pkg::item_type          head_item,
   input  nrtp_pkg::queue_status_type  queue_status,
   output logic                        pop,
   output logic                        rsp_valid,
   output nrtp_pkg::rsp_type           rsp_data,
   input  logic                        rsp_stall
);
   import nrtp_pkg::*;

   localparam int ACC_IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int STK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int FILL_W    = $clog2(STACK_DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [TS_W-1:0]   real_acc;
      logic [TS_W-1:0]   user_acc;
      logic [TS_W-1:0]   sys_acc;
      logic [MASK_W-1:0] mask;
   } acc_entry_type;

   // Accumulator table and its per-entry valid bits
   acc_entry_type        acc_mem [MAX_REGIONS];
   logic                 acc_valid_ff [MAX_REGIONS];
   acc_entry_type        rd_data_ff;
   logic                 rd_valid_ff;
   logic [ACC_IDX_W-1:0] rd_addr;
   logic [ACC_IDX_W-1:0] wr_addr;
   logic                 wr_en;
   acc_entry_type        wr_entry;
   acc_entry_type        rd_entry;

   // Region stack
   logic [REGION_W-1:0]  stack_ff [STACK_DEPTH];
   logic                 stack_wr_en;

   state_type            state_ff;
   state_type            state_in;
   item_type             item_ff;
   item_type             item_in;
   logic [FILL_W-1:0]    fill_ff;
   logic [FILL_W-1:0]    fill_in;
   logic [REGION_W-1:0]  active_ff;
   logic [REGION_W-1:0]  active_in;
   logic [TS_W-1:0]      istart_real_ff;
   logic [TS_W-1:0]      istart_real_in;
   logic [TS_W-1:0]      istart_user_ff;
   logic [TS_W-1:0]      istart_user_in;
   logic [TS_W-1:0]      istart_sys_ff;
   logic [TS_W-1:0]      istart_sys_in;
   logic [TS_W-1:0]      last_stop_ff;
   logic [TS_W-1:0]      last_stop_in;
   logic [TS_W-1:0]      delta_real_ff;
   logic [TS_W-1:0]      delta_real_in;
   logic [TS_W-1:0]      delta_user_ff;
   logic [TS_W-1:0]      delta_user_in;
   logic [TS_W-1:0]      delta_sys_ff;
   logic [TS_W-1:0]      delta_sys_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;

   logic                 out_free;
   logic                 exec_go;
   logic                 is_start;
   logic                 is_stop;
   logic                 is_read;
   logic                 stack_empty;
   logic                 stack_full;
   logic                 do_push;
   logic                 do_pop;
   logic                 do_charge;
   logic [FILL_W:0]      fill_wide;
   logic [FILL_W-1:0]    parent_pos;
   logic [REGION_W-1:0]  parent_region;
   logic [MASK_W-1:0]    child_bit;

   // Decode the transaction in execution
   assign is_start    = (item_ff.req.cmd == CMD_START);
   assign is_stop     = (item_ff.req.cmd == CMD_STOP);
   assign is_read     = (item_ff.req.cmd == CMD_READ);
   assign stack_empty = (fill_ff == '0);
   assign stack_full  = (fill_ff >= FILL_W'(STACK_DEPTH));
   assign do_push     = is_start && item_ff.region_ok && !stack_full;
   assign do_pop      = is_stop && !stack_empty;
   assign do_charge   = (do_push && !stack_empty) || do_pop;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign exec_go     = (state_ff == ST_EXEC) && out_free;
   assign pop         = (state_ff == ST_IDLE) && !queue_status.empty;

   // Parent of the region being stopped sits two below the fill mark
   assign fill_wide     = {1'b0, fill_ff};
   assign parent_pos    = fill_ff - FILL_W'(2);
   assign parent_region = stack_ff[parent_pos[STK_IDX_W-1:0]];

   // Charge the interval and mark the child in the current region's entry
   assign rd_entry  = rd_valid_ff ? rd_data_ff : '0;
   assign child_bit = do_push ? (MASK_W'(1) << item_ff.req.region) : '0;
   assign wr_entry.real_acc = rd_entry.real_acc + delta_real_ff;
   assign wr_entry.user_acc = rd_entry.user_acc + delta_user_ff;
   assign wr_entry.sys_acc  = rd_entry.sys_acc + delta_sys_ff;
   assign wr_entry.mask     = rd_entry.mask | child_bit;
   assign wr_en       = exec_go && do_charge;
   assign wr_addr     = ACC_IDX_W'(active_ff);
   assign rd_addr     = (head_item.req.cmd == CMD_READ) ?
                        ACC_IDX_W'(head_item.req.region) : ACC_IDX_W'(active_ff);
   assign stack_wr_en = exec_go && do_push;

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      fill_in        = fill_ff;
      active_in      = active_ff;
      istart_real_in = istart_real_ff;
      istart_user_in = istart_user_ff;
      istart_sys_in  = istart_sys_ff;
      last_stop_in   = last_stop_ff;
      delta_real_in  = delta_real_ff;
      delta_user_in  = delta_user_ff;
      delta_sys_in   = delta_sys_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // Take the next transaction and measure the intervals since the last marks
            if (pop) begin
               item_in       = head_item;
               delta_real_in = head_item.req.now_real_us - istart_real_ff;
               delta_user_in = head_item.req.now_user_us - istart_user_ff;
               delta_sys_in  = head_item.req.now_sys_us - istart_sys_ff;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Commit the transaction once the result register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
               if (do_charge) begin
                  last_stop_in = item_ff.req.now_real_us;
               end
               if (is_start) begin
                  if (!item_ff.region_ok) begin
                     rsp_data_in.status = STATUS_RANGE;
                  end else if (stack_full) begin
                     rsp_data_in.status = STATUS_FULL;
                  end else begin
                     fill_in                = fill_ff + 1'b1;
                     active_in              = item_ff.req.region;
                     istart_real_in         = item_ff.req.now_real_us;
                     istart_user_in         = item_ff.req.now_user_us;
                     istart_sys_in          = item_ff.req.now_sys_us;
                     rsp_data_in.event_time = item_ff.req.now_real_us;
                  end
               end else if (is_stop) begin
                  if (do_pop) begin
                     fill_in                = fill_ff - 1'b1;
                     rsp_data_in.event_time = item_ff.req.now_real_us;
                     if (fill_wide >= (FILL_W + 1)'(2)) begin
                        active_in      = parent_region;
                        istart_real_in = item_ff.req.now_real_us;
                        istart_user_in = item_ff.req.now_user_us;
                        istart_sys_in  = item_ff.req.now_sys_us;
                     end else begin
                        active_in = '0;
                     end
                  end else begin
                     rsp_data_in.event_time = last_stop_ff;
                  end
               end else if (is_read) begin
                  if (!item_ff.region_ok) begin
                     rsp_data_in.status = STATUS_RANGE;
                  end else begin
                     rsp_data_in.real_total = rd_entry.real_acc;
                     rsp_data_in.user_total = rd_entry.user_acc;
                     rsp_data_in.sys_total  = rd_entry.sys_acc;
                     rsp_data_in.child_mask = rd_entry.mask;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, stack pointer, interval marks and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fill_ff        <= '0;
         active_ff      <= '0;
         istart_real_ff <= '0;
         istart_user_ff <= '0;
         istart_sys_ff  <= '0;
         last_stop_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < MAX_REGIONS; i++) begin
            acc_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         active_ff      <= active_in;
         istart_real_ff <= istart_real_in;
         istart_user_ff <= istart_user_in;
         istart_sys_ff  <= istart_sys_in;
         last_stop_ff   <= last_stop_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (wr_en) begin
            acc_valid_ff[wr_addr] <= 1'b1;
         end
      end
      item_ff       <= item_in;
      delta_real_ff <= delta_real_in;
      delta_user_ff <= delta_user_in;
      delta_sys_ff  <= delta_sys_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Accumulator table: one registered read, one write
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_data_ff  <= acc_mem[rd_addr];
         rd_valid_ff <= acc_valid_ff[rd_addr];
      end
      if (wr_en) begin
         acc_mem[wr_addr] <= wr_entry;
      end
   end

   // Push the started region
   always_ff @(posedge clock) begin
      if (stack_wr_en) begin
         stack_ff[fill_ff[STK_IDX_W-1:0]] <= item_ff.req.region;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Stack never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(STACK_DEPTH))
      else $error("region stack overfilled");

   // A stalled execution keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && !out_free |=> (state_ff == ST_EXEC) && $stable(item_ff))
      else $error("transaction lost while result register busy");

   // An accepted start deepens the stack by exactly one
   assert property (@(posedge clock) disable iff (reset)
      exec_go && do_push |=> fill_ff == FILL_W'($past(fill_ff) + 1'b1))
      else $error("push did not advance the stack");

   // A new result only follows an execution cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result appeared without execution");

   // Table is never written and read-issued in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(wr_en && pop))
      else $error("accumulator table access overlap");

endmodule

// ===== hdl/nested_region_time_profiler.sv =====
// Top level of the nested region exclusive time profiler.
// In the back end a transaction first issues the registered read of the accumulator table,
// then, once the result register is free, adds the charged interval, writes the entry back
// and loads the result register; the next transaction is taken only after that. A two-entry
// queue between intake and execution lets the request side keep going while the result side
// stalls, until the queue fills. The accumulator table clears at reset through per-entry
// valid bits, so no clearing pass is needed and the block takes transactions from the first
// cycle after reset. Timestamps are 63-bit microsecond counts and totals wrap modulo 2^63.
module nested_region_time_profiler #(
   parameter int MAX_REGIONS = nrtp_pkg::MAX_REGIONS_DEF,
   parameter int STACK_DEPTH = nrtp_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [nrtp_pkg::COUNT_W-1:0]  csr_write_data,
   input  logic                          req_valid,
   input  nrtp_pkg::req_type             req_data,
   output logic                          req_stall,
   output logic                          rsp_valid,
   output nrtp_pkg::rsp_type             rsp_data,
   input  logic                          rsp_stall
);
   import nrtp_pkg::*;

   queue_status_type queue_status;
   logic             push_valid;
   item_type         push_item;
   item_type         head_item;
   logic             pop;

   nrtp_front #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_data         (req_data),
      .req_stall        (req_stall),
      .queue_status     (queue_status),
      .push_valid       (push_valid),
      .push_item        (push_item)
   );

   nrtp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_item    (push_item),
      .pop          (pop),
      .head_item    (head_item),
      .queue_status (queue_status)
   );

   nrtp_back #(
      .MAX_REGIONS (MAX_REGIONS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_item    (head_item),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_stall    (rsp_stall)
   );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the nested region time profiler: directed script, random sweep.
module testbench;
   import nrtp_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [TS_W-1:0]  TS_MAX = {TS_W{1'b1}};
   localparam int CYCLE_LIMIT   = 600000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;

   // One line of the opening script: a register write or a repeated transaction
   typedef struct packed {
      logic                is_csr;
      logic [COUNT_W-1:0]  csr_value;
      logic [4:0]          reps;
      logic                has_golden;
      req_type             req;
      rsp_type             golden;
   } step_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;
   logic               req_valid = 1'b0;
   req_type            req_data = '0;
   logic               req_stall;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               rsp_stall = 1'b0;

   // Shadow profiler state
   logic [COUNT_W-1:0]  prof_count;
   logic [REGION_W-1:0] nest_stack [STACK_DEPTH_DEF];
   int                  nest_depth;
   logic [REGION_W-1:0] cur_region;
   logic [63:0]         open_real, open_user, open_sys, stop_real;
   logic [63:0]         tot_real [MAX_REGIONS_DEF];
   logic [63:0]         tot_user [MAX_REGIONS_DEF];
   logic [63:0]         tot_sys  [MAX_REGIONS_DEF];
   logic [MASK_W-1:0]   kids     [MAX_REGIONS_DEF];

   // Time cursors of the random traffic
   logic [TS_W-1:0] at_real = '0, at_user = '0, at_sys = '0;

   rsp_type      pending_reports [$];
   step_row_type opening_script [$];
   rsp_type      next_due;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           send_pct = 0;
   int           stall_pct = 0;
   int           hold_asked = 0;
   int           hold_taken = 0;
   int           hold_left = 0;
   int           sweep_counts [8] = '{32, 0, 32, 1, 17, 32, 31, 9};

   nested_region_time_profiler u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_data         (req_data),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .rsp_stall        (rsp_stall)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Charge the running interval to the innermost region
   function automatic void charge_interval(input req_type r);
      tot_real[cur_region] += {1'b0, r.now_real_us} - open_real;
      tot_user[cur_region] += {1'b0, r.now_user_us} - open_user;
      tot_sys[cur_region]  += {1'b0, r.now_sys_us} - open_sys;
      stop_real = {1'b0, r.now_real_us};
   endfunction

   function automatic void open_interval(input req_type r);
      open_real = {1'b0, r.now_real_us};
      open_user = {1'b0, r.now_user_us};
      open_sys  = {1'b0, r.now_sys_us};
   endfunction

   // Advance the shadow state by one transaction and return its report
   function automatic rsp_type profile_step(input req_type r);
      rsp_type o;
      logic    in_range;
      o = '0;
      in_range = r.region < prof_count;
      case (r.cmd)
         CMD_START: begin
            if (!in_range) begin
               o.status = STATUS_RANGE;
            end else if (nest_depth >= STACK_DEPTH_DEF) begin
               o.status = STATUS_FULL;
            end else begin
               if (nest_depth > 0) begin
                  charge_interval(r);
                  kids[cur_region][r.region] = 1'b1;
               end
               nest_stack[nest_depth] = r.region;
               nest_depth++;
               cur_region = r.region;
               open_interval(r);
               o.event_time = r.now_real_us;
            end
         end
         CMD_STOP: begin
            if (nest_depth > 0) begin
               charge_interval(r);
               nest_depth--;
               if (nest_depth > 0) begin
                  cur_region = nest_stack[nest_depth - 1];
                  open_interval(r);
               end else begin
                  cur_region = '0;
               end
            end
            o.event_time = stop_real[TS_W-1:0];
         end
         CMD_READ: begin
            if (!in_range) begin
               o.status = STATUS_RANGE;
            end else begin
               o.real_total = tot_real[r.region][TS_W-1:0];
               o.user_total = tot_user[r.region][TS_W-1:0];
               o.sys_total  = tot_sys[r.region][TS_W-1:0];
               o.child_mask = kids[r.region];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic logic [TS_W-1:0] rand63();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[TS_W-1:0];
   endfunction

   // Mostly well-formed nesting with running clocks; some noise on top
   function automatic req_type next_request(input int start_bias);
      req_type r;
      int      roll;
      int      span;
      span = (prof_count > MAX_REGIONS_DEF) ? MAX_REGIONS_DEF : int'(prof_count);
      at_real += $urandom_range(4000);
      at_user += $urandom_range(4000);
      at_sys  += $urandom_range(4000);
      if ($urandom_range(49) == 0) at_real = rand63();
      if ($urandom_range(49) == 0) at_user = rand63();
      if ($urandom_range(49) == 0) at_sys = rand63();
      r.now_real_us = at_real;
      r.now_user_us = at_user;
      r.now_sys_us  = at_sys;
      roll = $urandom_range(99);
      if (roll < 15) begin
         r.cmd    = CMD_W'($urandom_range(3));
         r.region = REGION_W'($urandom_range(31));
         if ($urandom_range(1)) r.now_sys_us = rand63();
      end else begin
         roll = $urandom_range(99);
         r.region = (span > 0) ? REGION_W'($urandom_range(span - 1)) :
                                 REGION_W'($urandom_range(31));
         if (roll < start_bias || (nest_depth == 0 && roll < 70))
            r.cmd = CMD_START;
         else if (roll < start_bias + 25)
            r.cmd = CMD_STOP;
         else
            r.cmd = CMD_READ;
      end
      return r;
   endfunction

   function automatic void plan_csr(input logic [COUNT_W-1:0] value);
      step_row_type row;
      row = '0;
      row.is_csr    = 1'b1;
      row.csr_value = value;
      opening_script = {opening_script, row};
   endfunction

   function automatic void plan_req(input logic [CMD_W-1:0] cmd,
                                    input logic [REGION_W-1:0] region,
                                    input logic [TS_W-1:0] nr, nu, ns,
                                    input int reps, input logic golden_on,
                                    input logic [STATUS_W-1:0] status,
                                    input logic [TS_W-1:0] event_time);
      step_row_type row;
      row = '0;
      row.reps              = 5'(reps);
      row.req.cmd           = cmd;
      row.req.region        = region;
      row.req.now_real_us   = nr;
      row.req.now_user_us   = nu;
      row.req.now_sys_us    = ns;
      row.has_golden        = golden_on;
      row.golden.status     = status;
      row.golden.event_time = event_time;
      opening_script = {opening_script, row};
   endfunction

   // Offer one transaction, hold it until taken, then record its report
   task automatic send_item(input req_type r, input logic use_golden, input rsp_type golden);
      rsp_type predicted;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = profile_step(r);
      pending_reports = {pending_reports, (use_golden ? golden : predicted)};
      if (send_pct != 0 && $urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_pct);
      end
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_region_count(input logic [COUNT_W-1:0] value);
      drain_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      prof_count = value;
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // Check every accepted report against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, got %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            next_due = pending_reports.pop_front();
            compare_field("status", 64'(next_due.status), 64'(rsp_data.status));
            compare_field("event_time", 64'(next_due.event_time),
                          64'(rsp_data.event_time));
            compare_field("real_total", 64'(next_due.real_total),
                          64'(rsp_data.real_total));
            compare_field("user_total", 64'(next_due.user_total),
                          64'(rsp_data.user_total));
            compare_field("sys_total", 64'(next_due.sys_total), 64'(rsp_data.sys_total));
            compare_field("child_mask", 64'(next_due.child_mask),
                          64'(rsp_data.child_mask));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      req_type r;
      int      items;
      int      bias;
      int      mode;

      // Clear the shadow state to its reset values
      prof_count = '0;
      nest_depth = 0;
      cur_region = '0;
      open_real  = '0;
      open_user  = '0;
      open_sys   = '0;
      stop_real  = '0;
      for (int i = 0; i < MAX_REGIONS_DEF; i++) begin
         tot_real[i] = '0;
         tot_user[i] = '0;
         tot_sys[i]  = '0;
         kids[i]     = '0;
      end

      // Opening script: range errors with no regions, nesting, full stack, backwards time
      plan_req(CMD_START, 5'd0, 63'd5, 63'd5, 63'd5, 1, 1'b1, STATUS_RANGE, '0);
      plan_req(CMD_READ, 5'd31, '0, '0, '0, 1, 1'b1, STATUS_RANGE, '0);
      plan_req(CMD_STOP, 5'd0, 63'd9, 63'd9, 63'd9, 1, 1'b1, STATUS_OK, '0);
      plan_req(CMD_UNUSED, 5'd31, TS_MAX, TS_MAX, TS_MAX, 1, 1'b1, STATUS_OK, '0);
      plan_csr(6'd32);
      plan_req(CMD_READ, 5'd31, '0, '0, '0, 1, 1'b1, STATUS_OK, '0);
      plan_req(CMD_START, 5'd0, 63'd100, 63'd40, 63'd7, 1, 1'b1, STATUS_OK, 63'd100);
      plan_req(CMD_START, 5'd31, TS_MAX, TS_MAX, TS_MAX, 1, 1'b1, STATUS_OK, TS_MAX);
      plan_req(CMD_STOP, 5'd0, 63'd50, 63'd20, 63'd3, 1, 1'b0, STATUS_OK, '0);
      plan_req(CMD_STOP, 5'd31, '0, '0, '0, 1, 1'b0, STATUS_OK, '0);
      plan_req(CMD_READ, 5'd0, '0, '0, '0, 1, 1'b0, STATUS_OK, '0);
      plan_req(CMD_READ, 5'd31, '0, '0, '0, 1, 1'b0, STATUS_OK, '0);
      plan_req(CMD_START, 5'd5, 63'd1000, 63'd800, 63'd600, 1, 1'b1, STATUS_OK, 63'd1000);
      plan_req(CMD_START, 5'd7, 63'd2000, 63'd1500, 63'd900, 15, 1'b0, STATUS_OK, '0);
      plan_req(CMD_START, 5'd8, 63'd40000, 63'd30000, 63'd20000, 1, 1'b1, STATUS_FULL, '0);
      plan_req(CMD_STOP, 5'd0, 63'd50000, 63'd40000, 63'd30000, 16, 1'b0, STATUS_OK, '0);
      plan_req(CMD_STOP, 5'd0, 63'd90000, 63'd90000, 63'd90000, 1, 1'b0, STATUS_OK, '0);
      plan_req(CMD_READ, 5'd5, '0, '0, '0, 1, 1'b0, STATUS_OK, '0);
      plan_req(CMD_READ, 5'd7, '0, '0, '0, 1, 1'b0, STATUS_OK, '0);
      plan_csr(6'd1);
      plan_req(CMD_START, 5'd1, 63'd7, 63'd7, 63'd7, 1, 1'b1, STATUS_RANGE, '0);
      plan_req(CMD_START, 5'd0, 63'd123456, 63'd6543, 63'd321, 1, 1'b1, STATUS_OK,
               63'd123456);
      plan_req(CMD_READ, 5'd1, '0, '0, '0, 1, 1'b1, STATUS_RANGE, '0);
      plan_req(CMD_STOP, 5'd0, 63'd223456, 63'd7543, 63'd421, 1, 1'b0, STATUS_OK, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Walk the opening script
      foreach (opening_script[i]) begin
         if (opening_script[i].is_csr) begin
            write_region_count(opening_script[i].csr_value);
         end else begin
            for (int k = 0; k < opening_script[i].reps; k++) begin
               r = opening_script[i].req;
               r.now_real_us += TS_W'(1000 * k);
               r.now_user_us += TS_W'(1000 * k);
               r.now_sys_us  += TS_W'(1000 * k);
               send_item(r, opening_script[i].has_golden, opening_script[i].golden);
            end
         end
      end

      // Random sweep over region counts and idling modes
      for (int p = 0; p < 8; p++) begin
         write_region_count(COUNT_W'(sweep_counts[p]));
         mode      = p % 4;
         send_pct  = (mode == 1) ? 76 : (mode == 3) ? 25 : 0;
         stall_pct = (mode == 2) ? 76 : (mode == 3) ? 25 : 0;
         bias      = $urandom_range(20, 55);
         items     = (sweep_counts[p] == 0) ? 40 : 170;
         for (int n = 0; n < items; n++) begin
            // Hold off the receiver while the sender keeps pushing
            if (n == items / 2 && (p == 2 || p == 5)) hold_asked++;
            // Pause the sender until everything has come back
            if (n == items / 3 && p % 3 == 1) drain_all();
            send_item(next_request(bias), 1'b0, '0);
         end
      end

      drain_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/nrtp_pkg.sv
hdl/nrtp_front.sv
hdl/nrtp_queue.sv
hdl/nrtp_back.sv
hdl/nested_region_time_profiler.sv
dv/testbench.sv
